/* rtl/ddf_pkg.sv */
// ----------------------------------------------------------------------------
// ddf_pkg
// Shared types, widths and helpers for the decimal digit display framer.
// ----------------------------------------------------------------------------
package ddf_pkg;

	localparam int VALUE_W     = 31;
	localparam int COUNT_W     = 4;
	localparam int MAX_DIGITS  = 8;
	localparam int BCD_W       = 4 * MAX_DIGITS;
	localparam int IDX_W       = 3;
	localparam int FRAME_W     = 16;
	localparam int IN_DATA_W   = 40;
	localparam int DIGITS_DEF  = 8;
	localparam int STAGE_STEPS = 8;
	localparam int DAB_STAGES  = (VALUE_W + STAGE_STEPS - 1) / STAGE_STEPS;

	localparam logic [7:0] BLANK_CODE = 8'd15;

	// One number on its way through the converter
	typedef struct packed {
		logic [BCD_W-1:0]   bcd;
		logic [VALUE_W-1:0] bin;
		logic [COUNT_W-1:0] count;
		logic               ovf;
	} ddf_item_t;

	function automatic logic [31:0] pow10(input int n);
		logic [31:0] r;
		r = 32'd1;
		for (int i = 0; i < n; i++) begin
			r = r * 32'd10;
		end
		return r;
	endfunction

endpackage

/* rtl/ddf_dabble_stage.sv */
// ----------------------------------------------------------------------------
// ddf_dabble_stage
// One registered slice of the shift-and-add-3 binary to BCD converter.
// ----------------------------------------------------------------------------
module ddf_dabble_stage #(
	parameter int STEPS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ddf_pkg::ddf_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output ddf_pkg::ddf_item_t  out_item
);
	import ddf_pkg::*;

	ddf_item_t work;
	ddf_item_t item_s1;
	logic      valid_s1;

	// add 3 to every digit of five or more, then shift one bit in
	always_comb begin
		work = in_item;
		for (int s = 0; s < STEPS; s++) begin
			for (int d = 0; d < MAX_DIGITS; d++) begin
				if (work.bcd[4*d +: 4] >= 4'd5) begin
					work.bcd[4*d +: 4] = work.bcd[4*d +: 4] + 4'd3;
				end
			end
			work.bcd = {work.bcd[BCD_W-2:0], work.bin[VALUE_W-1]};
			work.bin = {work.bin[VALUE_W-2:0], 1'b0};
		end
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= work;
		end
	end

endmodule

/* rtl/ddf_serializer.sv */
// ----------------------------------------------------------------------------
// ddf_serializer
// Unrolls one converted number into its run of display frames.
// ----------------------------------------------------------------------------
module ddf_serializer #(
	parameter int DIGITS = ddf_pkg::DIGITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  ddf_pkg::ddf_item_t          in_item,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [ddf_pkg::FRAME_W-1:0] m_tdata,
	output logic                        m_tlast,
	output logic                        m_tuser
);
	import ddf_pkg::*;

	logic                busy_q;
	logic [IDX_W-1:0]    idx_q;
	logic [BCD_W-1:0]    digits_q;
	logic [COUNT_W-1:0]  count_q;
	logic                ovf_q;
	logic                emit;
	logic                last_idx;
	logic                take;
	logic [7:0]          code;

	assign emit     = busy_q && (!m_tvalid || m_tready);
	assign last_idx = (idx_q == IDX_W'(DIGITS - 1));
	assign in_ready = !busy_q || (emit && last_idx);
	assign take     = in_ready && in_valid;
	assign code     = ({1'b0, idx_q} < count_q) ? {4'b0, digits_q[3:0]} : BLANK_CODE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			idx_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (emit) begin
				busy_q <= !last_idx;
				idx_q  <= idx_q + 1'b1;
			end
			if (emit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			digits_q <= in_item.bcd;
			count_q  <= in_item.count;
			ovf_q    <= in_item.ovf;
		end else if (emit) begin
			digits_q <= {4'b0, digits_q[BCD_W-1:4]};
		end
		if (emit) begin
			m_tdata <= {8'(idx_q) + 8'd1, code};
			m_tlast <= last_idx;
			m_tuser <= last_idx && ovf_q;
		end
	end

endmodule

/* rtl/decimal_digit_display_framer.sv */
// ----------------------------------------------------------------------------
// decimal_digit_display_framer
// Converts a binary number to decimal and frames it for a digit display.
// ----------------------------------------------------------------------------
// Output: DIGITS frames per number, one a cycle while m_tready is high; the
//   single frame port sets the pace, the converter itself takes a number
//   every cycle unless the stage after it stalls.
// Reset: arst_n clears all valid bits and the frame counter; no data is lost
//   on stalls, no clearing pass is needed.
module decimal_digit_display_framer #(
	parameter int DIGITS = ddf_pkg::DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [30:0] value, [34:31] digit_count, [39:35] zero
	input  logic [ddf_pkg::IN_DATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [15:0] frame: [15:8] digit address, [7:0] code (15 = blank)
	output logic [ddf_pkg::FRAME_W-1:0]   m_tdata,
	output logic                          m_tlast,
	// [0] overflow, set on the last frame only
	output logic                          m_tuser
);
	import ddf_pkg::*;

	// value at or above this needs more digits than the display has
	localparam logic [31:0] OVF_LIMIT = pow10(DIGITS);

	logic [VALUE_W-1:0] in_value;
	logic [COUNT_W-1:0] in_count;
	logic [COUNT_W-1:0] sat_count;

	ddf_item_t item_s1;
	logic      valid_s1;

	ddf_item_t chain_item  [DAB_STAGES+1];
	logic      chain_valid [DAB_STAGES+1];
	logic      chain_ready [DAB_STAGES+1];

	assign in_value  = s_tdata[VALUE_W-1:0];
	assign in_count  = s_tdata[VALUE_W +: COUNT_W];
	// clip the digit count to the display width
	assign sat_count = (in_count > COUNT_W'(DIGITS)) ? COUNT_W'(DIGITS) : in_count;

	// Stage 1: capture the beat, clip the count and flag overflow up front
	assign s_tready = !valid_s1 || chain_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.bcd   <= '0;
			item_s1.bin   <= in_value;
			item_s1.count <= sat_count;
			item_s1.ovf   <= ({1'b0, in_value} >= OVF_LIMIT);
		end
	end

	assign chain_item[0]  = item_s1;
	assign chain_valid[0] = valid_s1;

	// Conversion stages: each one consumes up to STAGE_STEPS value bits.
	// BCD keeps eight digits; anything above drops, overflow already covers it.
	for (genvar g = 0; g < DAB_STAGES; g++) begin : g_dab
		localparam int LEFT  = VALUE_W - g * STAGE_STEPS;
		localparam int STEPS = (LEFT < STAGE_STEPS) ? LEFT : STAGE_STEPS;

		ddf_dabble_stage #(
			.STEPS(STEPS)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (chain_valid[g]),
			.in_ready (chain_ready[g]),
			.in_item  (chain_item[g]),
			.out_valid(chain_valid[g+1]),
			.out_ready(chain_ready[g+1]),
			.out_item (chain_item[g+1])
		);
	end

	// Frame output: hold one number, advance one position per accepted beat
	ddf_serializer #(
		.DIGITS(DIGITS)
	) u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chain_valid[DAB_STAGES]),
		.in_ready (chain_ready[DAB_STAGES]),
		.in_item  (chain_item[DAB_STAGES]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
